// File: src/sblc_pkg.sv
// ----------------------------------------------------------------------------
// sblc_pkg
// Types and constants shared by the size-budget LRU cache tag table.
// ----------------------------------------------------------------------------
package sblc_pkg;

    localparam int TAG_W   = 32;
    localparam int BYTES_W = 32;
    localparam int TOTAL_W = 40;

    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 40'd1073741824;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        EV_HIT    = 2'd0,
        EV_INSERT = 2'd1,
        EV_FAIL   = 2'd2,
        EV_EVICT  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [TAG_W-1:0]   object_tag;
        logic [BYTES_W-1:0] object_bytes;
        logic               fetch_ok;
    } req_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [TAG_W-1:0]   event_tag;
        logic [BYTES_W-1:0] event_bytes;
        logic [TOTAL_W-1:0] total_bytes;
        logic               last;
    } evt_t;

    // one word of the tag/size store
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    typedef enum logic [1:0] {
        RK_NOP,
        RK_TOUCH,
        RK_EVICT,
        RK_INSERT
    } rank_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_VSCAN,
        ST_VREAD,
        ST_VEMIT,
        ST_INSERT,
        ST_OUT
    } state_t;

endpackage

// File: src/sblc_ram.sv
// ----------------------------------------------------------------------------
// sblc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sblc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sblc_rank_table.sv
// ----------------------------------------------------------------------------
// sblc_rank_table
// Per-entry valid bits and recency ranks (0 = most recent), plus the
// occupancy count. Applies one touch, evict or insert per cycle.
// ----------------------------------------------------------------------------
module sblc_rank_table #(
    parameter int ENTRIES = 16,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int RANK_W = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sblc_pkg::rank_op_t  op,
    input  logic [IDX_W-1:0]    op_idx,
    input  logic [IDX_W-1:0]    rd_idx,
    output logic                rd_valid,
    output logic [RANK_W-1:0]   rd_rank,
    output logic [ENTRIES-1:0]  valid_vec,
    output logic [CNT_W-1:0]    count
);

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        logic [RANK_W-1:0] touch_rank;
        touch_rank = rank_reg[op_idx];
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        unique case (op)
            sblc_pkg::RK_NOP: begin
            end
            sblc_pkg::RK_TOUCH: begin
                // entries more recent than the touched one age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] < touch_rank)) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                rank_next[op_idx] = '0;
            end
            sblc_pkg::RK_EVICT: begin
                valid_next[op_idx] = 1'b0;
                count_next         = count_reg - CNT_W'(1);
            end
            sblc_pkg::RK_INSERT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                valid_next[op_idx] = 1'b1;
                rank_next[op_idx]  = '0;
                count_next         = count_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign rd_valid  = valid_reg[rd_idx];
    assign rd_rank   = rank_reg[rd_idx];
    assign valid_vec = valid_reg;
    assign count     = count_reg;

endmodule

// File: src/size_budget_lru_cache_top.sv
// ----------------------------------------------------------------------------
// size_budget_lru_cache_top
// Size-aware LRU tag table. Requests enter on s_, event beats leave on m_.
// A hit reports and refreshes recency; a failed miss reports only; a good
// miss evicts least recent entries (one beat each) while the budget or the
// table would overflow, then inserts and reports with last set.
//
// One request at a time: s_ready is high only while idle. The tag search
// walks the tag RAM one entry per cycle and stops early on a hit. Each
// eviction adds a rank scan, a RAM read, a beat and a recheck, in that
// order. Every beat sits in the output register until m_ready; the
// sequencer waits there, so a stalled receiver just holds the block.
// One shared 41-bit adder serves the budget compare and the saturating
// total updates. cfg_ready is always high; cfg_data sets byte_budget and
// should only be written while idle.
// Reset (aresetn low, synchronous) empties the table, zeroes the total and
// restores the 1 GiB budget. No clearing pass: ready right after reset.
// ----------------------------------------------------------------------------
module size_budget_lru_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sblc_pkg::req_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sblc_pkg::evt_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sblc_pkg::TOTAL_W-1:0]      cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SCAN_W = $clog2(ENTRIES + 1);
    localparam int SUM_W  = sblc_pkg::TOTAL_W + 1;
    localparam int WORD_W = sblc_pkg::TAG_W + sblc_pkg::BYTES_W;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(ENTRIES);
    localparam logic [SCAN_W-1:0] VSCAN_END = SCAN_W'(ENTRIES - 1);

    sblc_pkg::state_t             state_reg, state_next;
    sblc_pkg::req_t               req_reg, req_next;
    sblc_pkg::evt_t               out_reg, out_next;
    logic [sblc_pkg::TOTAL_W-1:0] budget_reg, budget_next;
    logic [sblc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [SCAN_W-1:0]            scan_reg, scan_next;
    logic [IDX_W-1:0]             victim_reg, victim_next;
    logic [RANK_W-1:0]            best_rank_reg, best_rank_next;
    logic                         vfound_reg, vfound_next;
    logic [IDX_W-1:0]             free_reg, free_next;
    logic                         free_found_reg, free_found_next;

    // table and RAM hookup
    sblc_pkg::rank_op_t  tbl_op;
    logic [IDX_W-1:0]    tbl_op_idx;
    logic [IDX_W-1:0]    tbl_rd_idx;
    logic                tbl_rd_valid;
    logic [RANK_W-1:0]   tbl_rd_rank;
    logic [ENTRIES-1:0]  tbl_valid_vec;
    logic [CNT_W-1:0]    tbl_count;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    sblc_pkg::entry_t    ram_wdata;
    logic [WORD_W-1:0]   ram_rdata_raw;
    sblc_pkg::entry_t    ram_rdata;

    logic [IDX_W-1:0]    scan_idx;
    logic [IDX_W-1:0]    prev_idx;
    logic                cmp_valid;
    logic                hit;

    // shared adder
    logic                alu_sub;
    logic [SUM_W-1:0]    alu_b;
    logic [SUM_W-1:0]    alu_sum;
    logic [sblc_pkg::TOTAL_W-1:0] alu_total;
    logic                over_budget;
    logic                evict_needed;

    sblc_rank_table #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (tbl_op),
        .op_idx    (tbl_op_idx),
        .rd_idx    (tbl_rd_idx),
        .rd_valid  (tbl_rd_valid),
        .rd_rank   (tbl_rd_rank),
        .valid_vec (tbl_valid_vec),
        .count     (tbl_count)
    );

    sblc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = sblc_pkg::entry_t'(ram_rdata_raw);
    assign ram_wdata = '{tag: req_reg.object_tag, bytes: req_reg.object_bytes};

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign prev_idx   = IDX_W'(scan_reg - SCAN_W'(1));
    // RAM read data is registered, so it lags the address
    assign cmp_valid  = (scan_reg != '0);
    assign tbl_rd_idx = (state_reg == sblc_pkg::ST_SEARCH) ? prev_idx : scan_idx;
    assign hit        = cmp_valid && tbl_rd_valid &&
                        (ram_rdata.tag == req_reg.object_tag);

    // subtract for an eviction, add the request size otherwise;
    // bit 40 flags overflow on add and borrow on subtract
    assign alu_sub = (state_reg == sblc_pkg::ST_VEMIT);
    assign alu_b   = alu_sub ? ~{{(SUM_W - sblc_pkg::BYTES_W){1'b0}}, ram_rdata.bytes}
                             :  {{(SUM_W - sblc_pkg::BYTES_W){1'b0}}, req_reg.object_bytes};
    assign alu_sum = {1'b0, total_reg} + alu_b + {{(SUM_W - 1){1'b0}}, alu_sub};
    assign alu_total = alu_sum[SUM_W-1] ? (alu_sub ? '0 : sblc_pkg::TOTAL_MAX)
                                        : alu_sum[sblc_pkg::TOTAL_W-1:0];
    assign over_budget  = (alu_sum > {1'b0, budget_reg});
    assign evict_needed = (tbl_count != '0) &&
                          (over_budget || (tbl_count == CNT_W'(ENTRIES)));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sblc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sblc_pkg::ST_SEARCH;
                end
            end
            sblc_pkg::ST_SEARCH: begin
                priority if (hit) begin
                    state_next = sblc_pkg::ST_OUT;
                end else if (scan_reg == SCAN_LAST) begin
                    state_next = req_reg.fetch_ok ? sblc_pkg::ST_CHECK : sblc_pkg::ST_OUT;
                end else begin
                    state_next = sblc_pkg::ST_SEARCH;
                end
            end
            sblc_pkg::ST_CHECK: begin
                state_next = evict_needed ? sblc_pkg::ST_VSCAN : sblc_pkg::ST_INSERT;
            end
            sblc_pkg::ST_VSCAN: begin
                if (scan_reg == VSCAN_END) begin
                    state_next = sblc_pkg::ST_VREAD;
                end
            end
            sblc_pkg::ST_VREAD:  state_next = sblc_pkg::ST_VEMIT;
            sblc_pkg::ST_VEMIT:  state_next = sblc_pkg::ST_OUT;
            sblc_pkg::ST_INSERT: state_next = sblc_pkg::ST_OUT;
            sblc_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = out_reg.last ? sblc_pkg::ST_IDLE : sblc_pkg::ST_CHECK;
                end
            end
            default: state_next = sblc_pkg::ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        req_next        = req_reg;
        out_next        = out_reg;
        total_next      = total_reg;
        scan_next       = scan_reg;
        victim_next     = victim_reg;
        best_rank_next  = best_rank_reg;
        vfound_next     = vfound_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        tbl_op          = sblc_pkg::RK_NOP;
        tbl_op_idx      = free_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = scan_idx;
        unique case (state_reg)
            sblc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_data;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                end
            end
            sblc_pkg::ST_SEARCH: begin
                ram_re    = (scan_reg != SCAN_LAST);
                scan_next = scan_reg + SCAN_W'(1);
                if (hit) begin
                    tbl_op               = sblc_pkg::RK_TOUCH;
                    tbl_op_idx           = prev_idx;
                    out_next.event_kind  = sblc_pkg::EV_HIT;
                    out_next.event_tag   = req_reg.object_tag;
                    out_next.event_bytes = '0;
                    out_next.total_bytes = total_reg;
                    out_next.last        = 1'b1;
                end else begin
                    // remember the first free slot for a later insert
                    if (cmp_valid && !tbl_rd_valid && !free_found_reg) begin
                        free_next       = prev_idx;
                        free_found_next = 1'b1;
                    end
                    if ((scan_reg == SCAN_LAST) && !req_reg.fetch_ok) begin
                        out_next.event_kind  = sblc_pkg::EV_FAIL;
                        out_next.event_tag   = req_reg.object_tag;
                        out_next.event_bytes = '0;
                        out_next.total_bytes = total_reg;
                        out_next.last        = 1'b1;
                    end
                end
            end
            sblc_pkg::ST_CHECK: begin
                scan_next   = '0;
                vfound_next = 1'b0;
            end
            sblc_pkg::ST_VSCAN: begin
                scan_next = scan_reg + SCAN_W'(1);
                if (tbl_rd_valid && (!vfound_reg || (tbl_rd_rank > best_rank_reg))) begin
                    victim_next    = scan_idx;
                    best_rank_next = tbl_rd_rank;
                    vfound_next    = 1'b1;
                end
            end
            sblc_pkg::ST_VREAD: begin
                ram_re    = 1'b1;
                ram_raddr = victim_reg;
            end
            sblc_pkg::ST_VEMIT: begin
                tbl_op               = sblc_pkg::RK_EVICT;
                tbl_op_idx           = victim_reg;
                total_next           = alu_total;
                out_next.event_kind  = sblc_pkg::EV_EVICT;
                out_next.event_tag   = ram_rdata.tag;
                out_next.event_bytes = ram_rdata.bytes;
                out_next.total_bytes = alu_total;
                out_next.last        = 1'b0;
                if (!free_found_reg || (victim_reg < free_reg)) begin
                    free_next       = victim_reg;
                    free_found_next = 1'b1;
                end
            end
            sblc_pkg::ST_INSERT: begin
                ram_we               = 1'b1;
                tbl_op               = sblc_pkg::RK_INSERT;
                tbl_op_idx           = free_reg;
                total_next           = alu_total;
                out_next.event_kind  = sblc_pkg::EV_INSERT;
                out_next.event_tag   = req_reg.object_tag;
                out_next.event_bytes = req_reg.object_bytes;
                out_next.total_bytes = alu_total;
                out_next.last        = 1'b1;
            end
            sblc_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    assign budget_next = cfg_valid ? cfg_data : budget_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sblc_pkg::ST_IDLE;
            budget_reg     <= sblc_pkg::BUDGET_RESET;
            total_reg      <= '0;
            scan_reg       <= '0;
            vfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            budget_reg     <= budget_next;
            total_reg      <= total_next;
            scan_reg       <= scan_next;
            vfound_reg     <= vfound_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        out_reg       <= out_next;
        victim_reg    <= victim_next;
        best_rank_reg <= best_rank_next;
        free_reg      <= free_next;
    end

    assign s_ready   = (state_reg == sblc_pkg::ST_IDLE);
    assign m_valid   = (state_reg == sblc_pkg::ST_OUT);
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tbl_valid_vec) == int'(tbl_count))
        else $error("occupancy count out of step with valid bits");

    // a beat always reports the running total as it stands
    a_beat_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.total_bytes == total_reg))
        else $error("beat total differs from running total");

    // an eviction scan always finds a victim
    a_victim_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sblc_pkg::ST_VREAD) |-> vfound_reg)
        else $error("eviction scan found no valid entry");

    // insert lands on a known free slot
    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sblc_pkg::ST_INSERT) |-> (free_found_reg && !tbl_valid_vec[free_reg]))
        else $error("insert slot is not free");

endmodule

// File: verif/tb_size_budget_lru_cache_top.sv
// ----------------------------------------------------------------------------
// tb_size_budget_lru_cache_top
// Self-checking bench for the size-budget LRU tag table. A class mirrors the
// table (tags, sizes, recency, byte total, budget) and queues the event beats
// each accepted request must produce; every m_ beat is checked field by field
// against the oldest queued one. A directed opener hits the corner cases,
// then random traffic over a small tag pool runs under a series of budgets
// and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_size_budget_lru_cache_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES        = 16;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PASS = 40;
    localparam int POOL_SIZE      = 24;
    localparam int SETTLE_CYCLES  = 2 * ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // ------------------------------------------------------------------
    // Mirror of the tag table plus the queue of event beats still owed
    // ------------------------------------------------------------------
    class lru_table_model;
        logic [sblc_pkg::TAG_W-1:0]   slot_tag   [ENTRIES];
        logic [sblc_pkg::BYTES_W-1:0] slot_bytes [ENTRIES];
        bit                           slot_used  [ENTRIES];
        int unsigned                  slot_age   [ENTRIES];
        logic [sblc_pkg::TOTAL_W-1:0] cached_sum;
        logic [sblc_pkg::TOTAL_W-1:0] budget;
        sblc_pkg::evt_t               owed_events[$];
        int unsigned                  mismatches;
        int unsigned                  requests, beats, hits, inserts, fails, evictions;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            cached_sum = '0;
            budget     = sblc_pkg::BUDGET_RESET;
            mismatches = 0;
            requests   = 0;
            beats      = 0;
            hits       = 0;
            inserts    = 0;
            fails      = 0;
            evictions  = 0;
        endfunction

        // entries more recent than the given age get one step older
        function void age_newer(int unsigned limit);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] < limit)
                    slot_age[i]++;
        endfunction

        function void owe(sblc_pkg::event_kind_t kind, logic [sblc_pkg::TAG_W-1:0] tag,
                          logic [sblc_pkg::BYTES_W-1:0] nbytes, logic lst);
            sblc_pkg::evt_t e;
            e.event_kind  = kind;
            e.event_tag   = tag;
            e.event_bytes = nbytes;
            e.total_bytes = cached_sum;
            e.last        = lst;
            owed_events.push_back(e);
        endfunction

        function void admit_request(sblc_pkg::req_t r);
            int                         hit_slot;
            int                         victim;
            int                         free_slot;
            int unsigned                live;
            logic [sblc_pkg::TOTAL_W:0] sum;
            requests++;
            hit_slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && slot_tag[i] == r.object_tag) begin
                    hit_slot = i;
                    break;
                end
            end
            if (hit_slot >= 0) begin
                age_newer(slot_age[hit_slot]);
                slot_age[hit_slot] = 0;
                owe(sblc_pkg::EV_HIT, r.object_tag, '0, 1'b1);
                return;
            end
            if (!r.fetch_ok) begin
                owe(sblc_pkg::EV_FAIL, r.object_tag, '0, 1'b1);
                return;
            end
            live = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    live++;
            sum = {1'b0, cached_sum} + r.object_bytes;
            while (live > 0 && (sum > {1'b0, budget} || live >= ENTRIES)) begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                slot_used[victim] = 1'b0;
                cached_sum = (cached_sum >= slot_bytes[victim]) ?
                             cached_sum - slot_bytes[victim] : '0;
                owe(sblc_pkg::EV_EVICT, slot_tag[victim], slot_bytes[victim], 1'b0);
                live--;
                sum = {1'b0, cached_sum} + r.object_bytes;
            end
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!slot_used[i]) begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot >= 0) begin
                age_newer(ENTRIES);
                slot_used[free_slot]  = 1'b1;
                slot_tag[free_slot]   = r.object_tag;
                slot_bytes[free_slot] = r.object_bytes;
                slot_age[free_slot]   = 0;
            end
            sum = {1'b0, cached_sum} + r.object_bytes;
            cached_sum = sum[sblc_pkg::TOTAL_W] ? sblc_pkg::TOTAL_MAX
                                                : sum[sblc_pkg::TOTAL_W-1:0];
            owe(sblc_pkg::EV_INSERT, r.object_tag, r.object_bytes, 1'b1);
        endfunction

        function void flag(string what, sblc_pkg::evt_t want, sblc_pkg::evt_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t MISMATCH %s: exp kind=%0d tag=%h bytes=%h total=%h last=%b",
                         $realtime, what, want.event_kind, want.event_tag,
                         want.event_bytes, want.total_bytes, want.last);
                $display("                     got kind=%0d tag=%h bytes=%h total=%h last=%b",
                         got.event_kind, got.event_tag, got.event_bytes,
                         got.total_bytes, got.last);
            end
        endfunction

        function void compare_event(sblc_pkg::evt_t got);
            sblc_pkg::evt_t want;
            beats++;
            if (owed_events.size() == 0) begin
                want = '0;
                flag("beat with nothing owed", want, got);
                return;
            end
            want = owed_events.pop_front();
            case (want.event_kind)
                sblc_pkg::EV_HIT:    hits++;
                sblc_pkg::EV_INSERT: inserts++;
                sblc_pkg::EV_FAIL:   fails++;
                default:             evictions++;
            endcase
            if (got.event_kind !== want.event_kind || got.event_tag !== want.event_tag ||
                got.event_bytes !== want.event_bytes ||
                got.total_bytes !== want.total_bytes || got.last !== want.last)
                flag("event beat", want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------
    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    sblc_pkg::req_t               s_data    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    sblc_pkg::evt_t               m_data;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [sblc_pkg::TOTAL_W-1:0] cfg_data  = '0;

    lru_table_model               cache_model = new();
    int unsigned                  gap_pct     = 0;
    int unsigned                  stall_pct   = 0;
    int unsigned                  quiet_cycles = 0;
    int unsigned                  budget_writes = 0;
    logic [sblc_pkg::TAG_W-1:0]   tag_pool [POOL_SIZE];

    size_budget_lru_cache_top #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // beat monitor: feeds the mirror and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cache_model.budget = cfg_data;
                budget_writes++;
            end
            if (s_valid && s_ready)
                cache_model.admit_request(s_data);
            if (m_valid && m_ready)
                cache_model.compare_event(m_data);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(negedge aclk);
        $display("watchdog: no beat for %0d cycles, %0d events still owed",
                 WATCHDOG_LIMIT, cache_model.owed_events.size());
        $display("[size_budget_lru_cache_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 82; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 82; end
            IDLE_BOTH:     begin gap_pct = 7;  stall_pct = 7;  end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    function automatic sblc_pkg::req_t make_req(logic [sblc_pkg::TAG_W-1:0] tag,
                                                logic [sblc_pkg::BYTES_W-1:0] nbytes,
                                                logic ok);
        sblc_pkg::req_t r;
        r.object_tag   = tag;
        r.object_bytes = nbytes;
        r.fetch_ok     = ok;
        return r;
    endfunction

    // mostly pool tags for hits, sizes scaled to the budget so it bites
    function automatic sblc_pkg::req_t random_req();
        logic [sblc_pkg::TAG_W-1:0]   tag;
        logic [sblc_pkg::BYTES_W-1:0] nbytes;
        logic [sblc_pkg::BYTES_W-1:0] span;
        logic [sblc_pkg::TOTAL_W-1:0] b;
        b    = cache_model.budget;
        tag  = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
        span = (b == '0 || b > 40'hFFFF_FFFF) ? 32'hFFFF : b[sblc_pkg::BYTES_W-1:0] / 4;
        case ($urandom_range(0, 9))
            0:       nbytes = '0;
            1:       nbytes = '1;
            2, 3:    nbytes = $urandom;
            default: nbytes = $urandom_range(0, span);
        endcase
        return make_req(tag, nbytes, $urandom_range(0, 99) < 85);
    endfunction

    // called and returns at a falling edge; valid stays up for back-to-back beats
    task automatic send_req(input sblc_pkg::req_t r);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = r;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (cache_model.owed_events.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_budget(input logic [sblc_pkg::TOTAL_W-1:0] value);
        drain();
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    initial begin
        logic [sblc_pkg::TOTAL_W-1:0] budget_plan [PHASES];
        logic [63:0]                  wide;

        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = $urandom;
        wide = {$urandom, $urandom};
        budget_plan[0] = '0;
        budget_plan[1] = sblc_pkg::TOTAL_MAX;
        budget_plan[2] = 40'd6000;
        budget_plan[3] = sblc_pkg::BUDGET_RESET;
        budget_plan[4] = 40'($urandom_range(1000, 1000000));
        budget_plan[5] = 40'hFFFF_FFFF;
        budget_plan[6] = 40'd300000;
        budget_plan[7] = wide[sblc_pkg::TOTAL_W-1:0];

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        set_idle(IDLE_NONE);

        // directed opener at the reset budget
        send_req(make_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0)); // failed miss, empty table
        send_req(make_req(32'hFFFF_FFFF, 32'h0000_0000, 1'b1)); // zero-size insert
        send_req(make_req(32'hFFFF_FFFF, 32'd123, 1'b0));       // hit ignores fetch flag
        send_req(make_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1)); // oversized: flush, insert
        send_req(make_req(32'h0000_0000, 32'h0000_0000, 1'b1)); // hit
        send_req(make_req(32'hA5A5_A5A5, 32'd1, 1'b1));         // budget eviction
        for (int i = 1; i < ENTRIES; i++)
            send_req(make_req(32'(i), 32'(i * 256), 1'b1));     // fill the table
        send_req(make_req(32'd16, 32'd7, 1'b1));                 // full-table eviction
        send_req(make_req(32'd1, 32'd0, 1'b1));                  // refresh the oldest
        send_req(make_req(32'd17, 32'd9, 1'b1));                 // evicts next oldest
        send_req(make_req(32'h5A5A_5A5A, 32'd0, 1'b0));

        // budget sweeps with random traffic; lowering the budget hits a full table
        for (int p = 0; p < PHASES; p++) begin
            write_budget(budget_plan[p]);
            set_idle(idle_mode_t'(p % 4));
            repeat (ITEMS_PER_PASS) send_req(random_req());
        end

        drain();
        if (cache_model.owed_events.size() != 0)
            cache_model.mismatches++;

        $display("covered %0d requests and %0d event beats over %0d budget settings",
                 cache_model.requests, cache_model.beats, budget_writes);
        $display("  hits %0d, inserts %0d, failed fetches %0d, evictions %0d; mismatches %0d",
                 cache_model.hits, cache_model.inserts, cache_model.fails,
                 cache_model.evictions, cache_model.mismatches);
        if (cache_model.mismatches == 0)
            $display("[size_budget_lru_cache_top] OK");
        else
            $display("[size_budget_lru_cache_top] ERROR");
        $finish;
    end

endmodule
